/* rtl/core/sle_pkg.sv */
// shared types and constants for the sorted list engine
// no dependencies; imported by every module of the block but sle_ram
package sle_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_REMOVE  = 2'd1,
        REQ_SEARCH  = 2'd2,
        REQ_REPLACE = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_RANGE    = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_EV,
        S_REM_RD,
        S_REM_EV,
        S_SRC_RD,
        S_SRC_EV,
        S_DRP_RD,
        S_DRP_EV,
        S_FIN
    } t_state;

    typedef struct packed {
        t_status            status;
        logic [IDX_W-1:0]   found_index;
        logic [CNT_W-1:0]   entry_count;
    } t_result;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [VAL_W-1:0]   wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr;
    } t_ram_req;

endpackage

/* rtl/core/sle_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/sle_seq.sv */
// request sequencer: walks the entry ram one entry per read/evaluate pair,
// using one signed compare against the request value; depends on sle_pkg
module sle_seq (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    output logic                                o_req_ready,
    input  sle_pkg::t_req                       i_req_type,
    input  logic signed [sle_pkg::VAL_W-1:0]    i_item_value,
    input  logic [sle_pkg::IDX_W-1:0]           i_position,
    output sle_pkg::t_ram_req                   o_ram,
    input  logic [sle_pkg::VAL_W-1:0]           i_ram_rdata,
    output logic                                o_res_valid,
    output sle_pkg::t_result                    o_res,
    input  logic                                i_res_take
);
    import sle_pkg::*;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_i, n_i;
    logic [CNT_W-1:0]          r_w, n_w;
    logic signed [VAL_W-1:0]   r_val, n_val;
    t_status                   r_status, n_status;
    logic [IDX_W-1:0]          r_idx, n_idx;

    logic [CNT_W-1:0]          w_i_dec, w_i_inc;
    logic                      w_lt, w_eq, w_gt;
    logic                      w_full, w_empty, w_range;

    assign w_i_dec = r_i - CNT_W'(1);
    assign w_i_inc = r_i + CNT_W'(1);

    // the shared compare unit: stored entry against request value
    assign w_lt = $signed(i_ram_rdata) < r_val;
    assign w_eq = i_ram_rdata == r_val;
    assign w_gt = !w_lt && !w_eq;

    assign w_full  = r_count >= CNT_W'(CAPACITY);
    assign w_empty = r_count == '0;
    assign w_range = {1'b0, i_position} >= r_count;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    case (i_req_type)
                        REQ_INSERT:  n_state = w_full  ? S_FIN : S_INS_RD;
                        REQ_REMOVE:  n_state = w_empty ? S_FIN : S_REM_RD;
                        REQ_SEARCH:  n_state = S_SRC_RD;
                        REQ_REPLACE: n_state = w_range ? S_FIN : S_DRP_RD;
                        default:     n_state = S_FIN;
                    endcase
                end
            end
            S_INS_RD: n_state = (r_i == '0) ? S_FIN : S_INS_EV;
            S_INS_EV: n_state = w_lt ? S_FIN : S_INS_RD;
            S_REM_RD: n_state = (r_i == r_count) ? S_FIN : S_REM_EV;
            S_REM_EV: n_state = S_REM_RD;
            S_SRC_RD: n_state = (r_i == r_count) ? S_FIN : S_SRC_EV;
            S_SRC_EV: n_state = (w_eq || w_gt) ? S_FIN : S_SRC_RD;
            S_DRP_RD: n_state = (w_i_inc >= r_count) ? S_INS_RD : S_DRP_EV;
            S_DRP_EV: n_state = S_DRP_RD;
            S_FIN:    n_state = i_res_take ? S_IDLE : S_FIN;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_count     = r_count;
        n_i         = r_i;
        n_w         = r_w;
        n_val       = r_val;
        n_status    = r_status;
        n_idx       = r_idx;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_i[IDX_W-1:0];
        o_ram.wdata = r_val;
        o_ram.re    = 1'b0;
        o_ram.raddr = r_i[IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_val    = i_item_value;
                    n_status = ST_OK;
                    n_idx    = '0;
                    n_i      = '0;
                    n_w      = '0;
                    case (i_req_type)
                        REQ_INSERT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_i = r_count;
                            end
                        end
                        REQ_REMOVE: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end
                        end
                        REQ_SEARCH: begin
                        end
                        REQ_REPLACE: begin
                            if (w_range) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_i = {1'b0, i_position};
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // insert walks down from the top, moving entries not below the value up by one
            S_INS_RD: begin
                if (r_i == '0) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = '0;
                    n_count     = r_count + CNT_W'(1);
                end else begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = w_i_dec[IDX_W-1:0];
                end
            end
            S_INS_EV: begin
                o_ram.we = 1'b1;
                if (w_lt) begin
                    n_count = r_count + CNT_W'(1);
                end else begin
                    o_ram.wdata = i_ram_rdata;
                    n_i         = w_i_dec;
                end
            end
            // remove compacts the list, r_i reads and r_w writes
            S_REM_RD: begin
                if (r_i == r_count) begin
                    n_count  = r_w;
                    n_status = (r_w == r_count) ? ST_NOTFOUND : ST_OK;
                end else begin
                    o_ram.re = 1'b1;
                end
            end
            S_REM_EV: begin
                if (!w_eq) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_w[IDX_W-1:0];
                    o_ram.wdata = i_ram_rdata;
                    n_w         = r_w + CNT_W'(1);
                end
                n_i = w_i_inc;
            end
            S_SRC_RD: begin
                if (r_i == r_count) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    o_ram.re = 1'b1;
                end
            end
            S_SRC_EV: begin
                if (w_eq) begin
                    n_idx = r_i[IDX_W-1:0];
                end else if (w_gt) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    n_i = w_i_inc;
                end
            end
            // replace first closes the gap at the position, then inserts
            S_DRP_RD: begin
                if (w_i_inc >= r_count) begin
                    n_count = r_count - CNT_W'(1);
                    n_i     = r_count - CNT_W'(1);
                end else begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = w_i_inc[IDX_W-1:0];
                end
            end
            S_DRP_EV: begin
                o_ram.we    = 1'b1;
                o_ram.wdata = i_ram_rdata;
                n_i         = w_i_inc;
            end
            S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_w      <= n_w;
        r_val    <= n_val;
        r_status <= n_status;
        r_idx    <= n_idx;
    end

    assign o_req_ready           = r_state == S_IDLE;
    assign o_res_valid           = r_state == S_FIN;
    assign o_res.status          = r_status;
    assign o_res.found_index     = r_idx;
    assign o_res.entry_count     = r_count;

endmodule

/* rtl/core/sorted_list_engine.sv */
// sorted list engine: up to CAPACITY signed values kept in ascending order
// throughput: one request at a time; the next is taken while the result waits
// synchronous active-low reset empties the list; entry ram is not cleared
// depends on sle_pkg, sle_ram, sle_seq
module sorted_list_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_req_type,
    input  logic signed [sle_pkg::VAL_W-1:0]    i_item_value,
    input  logic [sle_pkg::IDX_W-1:0]           i_position,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [2:0]                          o_status,
    output logic [sle_pkg::IDX_W-1:0]           o_found_index,
    output logic [sle_pkg::CNT_W-1:0]           o_entry_count
);
    import sle_pkg::*;

    t_ram_req          w_ram;
    logic [VAL_W-1:0]  w_rdata;
    logic              w_res_valid;
    t_result           w_res;
    logic              w_take;

    logic              r_out_valid, n_out_valid;
    t_result           r_out;

    sle_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .o_req_ready  (o_ready),
        .i_req_type   (t_req'(i_req_type)),
        .i_item_value (i_item_value),
        .i_position   (i_position),
        .o_ram        (w_ram),
        .i_ram_rdata  (w_rdata),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .i_res_take   (w_take)
    );

    sle_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    // output register frees the sequencer as soon as the slot is open
    assign w_take = !r_out_valid || i_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_res_valid && w_take) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_take) begin
            r_out <= w_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_found_index = r_out.found_index;
    assign o_entry_count = r_out.entry_count;

endmodule

/* rtl/core/sle_checker.sv */
// port-level checks for the sorted list engine, bound to the top level
// depends on sle_pkg and sorted_list_engine
module sle_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_valid,
    input  logic                                i_ready,
    input  logic [2:0]                          o_status,
    input  logic [sle_pkg::IDX_W-1:0]           o_found_index,
    input  logic [sle_pkg::CNT_W-1:0]           o_entry_count
);
    import sle_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
            && $stable(o_found_index) && $stable(o_entry_count))
        else $error("result changed while stalled");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entry_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_entry_count == CNT_W'(CAPACITY))
        else $error("full reported below capacity");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_entry_count == '0)
        else $error("empty reported with entries");

    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_found_index == '0)
        else $error("index set on failed request");

endmodule

bind sorted_list_engine sle_checker u_sle_checker (.*);

/* test/sorted_list_engine_tb.sv */
// testbench for sorted_list_engine: directed and random requests, with an ordered-list
// predictor in a scoreboard class; random idling on both sides of the block
// depends on sle_pkg and the sorted_list_engine rtl
module sorted_list_engine_tb;
    import sle_pkg::*;

    localparam int NUM_RANDOM = 1300;
    localparam int CALM_TAIL  = 150;
    localparam int SETTLE     = 4 * CAPACITY + 8;

    // predicts each result from a queue copy of the list and checks results in order
    class list_scoreboard;
        logic signed [VAL_W-1:0] stored[$];
        t_result                 awaited[$];
        int                      errors;
        int                      checked;

        function new();
            errors  = 0;
            checked = 0;
        endfunction

        function int occupancy();
            return stored.size();
        endfunction

        function t_status put_ordered(logic signed [VAL_W-1:0] v);
            int at;
            at = 0;
            if (stored.size() >= CAPACITY) return ST_FULL;
            while (at < stored.size() && stored[at] < v) at++;
            stored.insert(at, v);
            return ST_OK;
        endfunction

        function void note_request(t_req req, logic signed [VAL_W-1:0] v,
                                   logic [IDX_W-1:0] pos);
            t_result r;
            int      i;
            bit      removed;
            r.status      = ST_OK;
            r.found_index = '0;
            removed       = 1'b0;
            case (req)
                REQ_INSERT: begin
                    r.status = put_ordered(v);
                end
                REQ_REMOVE: begin
                    if (stored.size() == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        i = 0;
                        while (i < stored.size()) begin
                            if (stored[i] == v) begin
                                stored.delete(i);
                                removed = 1'b1;
                            end else if (stored[i] > v) begin
                                break;
                            end else begin
                                i++;
                            end
                        end
                        if (!removed) r.status = ST_NOTFOUND;
                    end
                end
                REQ_SEARCH: begin
                    r.status = ST_NOTFOUND;
                    for (i = 0; i < stored.size(); i++) begin
                        if (stored[i] == v) begin
                            r.status      = ST_OK;
                            r.found_index = IDX_W'(i);
                            break;
                        end
                        if (stored[i] > v) break;
                    end
                end
                default: begin
                    if (pos >= stored.size()) begin
                        r.status = ST_RANGE;
                    end else begin
                        stored.delete(pos);
                        r.status = put_ordered(v);
                    end
                end
            endcase
            r.entry_count = CNT_W'(stored.size());
            awaited.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("result %0d: %s", checked, msg);
        endtask

        task check_result(logic [2:0] st, logic [IDX_W-1:0] idx, logic [CNT_W-1:0] cnt);
            t_result want;
            checked++;
            if (awaited.size() == 0) begin
                report($sformatf("unrequested result status %0d count %0d", st, cnt));
                return;
            end
            want = awaited.pop_front();
            if (st !== want.status)
                report($sformatf("status %0d, predicted %0d", st, want.status));
            if (idx !== want.found_index)
                report($sformatf("found index %0d, predicted %0d", idx, want.found_index));
            if (cnt !== want.entry_count)
                report($sformatf("entry count %0d, predicted %0d", cnt, want.entry_count));
        endtask
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic [1:0]                 i_req_type;
    logic signed [VAL_W-1:0]    i_item_value;
    logic [IDX_W-1:0]           i_position;
    logic                       o_valid;
    logic                       i_ready;
    logic [2:0]                 o_status;
    logic [IDX_W-1:0]           o_found_index;
    logic [CNT_W-1:0]           o_entry_count;

    list_scoreboard sb;
    bit             idle_on = 1'b1;

    sorted_list_engine i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_item_value  (i_item_value),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_entry_count (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("sorted_list_engine: mismatch");
        $finish;
    end

    // returns at the edge where the request was taken
    task automatic send_request(t_req req, logic signed [VAL_W-1:0] v, logic [IDX_W-1:0] pos);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_req_type   <= req;
        i_item_value <= v;
        i_position   <= pos;
        i_valid      <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(req, v, pos);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.awaited.size() != 0) @(posedge i_clk);
    endtask

    // small values collide often so removes and searches hit
    function automatic logic signed [VAL_W-1:0] pick_value();
        int k;
        k = $urandom_range(0, 16);
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh8000_0001;
                    default: return 32'sh7fff_fffe;
                endcase
            end
            default: return k - 8;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_position();
        int n;
        n = sb.occupancy();
        if ($urandom_range(0, 4) == 0) return IDX_W'($urandom_range(0, 63));
        if ($urandom_range(0, 9) == 0 || n == 0) return IDX_W'(n);
        return IDX_W'($urandom_range(0, n - 1));
    endfunction

    function automatic t_req pick_request(int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0: return (r < 70) ? REQ_INSERT : (r < 85) ? REQ_SEARCH :
                      (r < 90) ? REQ_REMOVE : REQ_REPLACE;
            1: return (r < 45) ? REQ_REMOVE : (r < 65) ? REQ_INSERT :
                      (r < 85) ? REQ_SEARCH : REQ_REPLACE;
            default: return t_req'(r % 4);
        endcase
    endfunction

    // result side: random stall bursts, checks every accepted result
    initial begin
        int stall_left;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_result(o_status, o_found_index, o_entry_count);
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 14);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        int sent;
        int mode;
        int len;
        sb           = new();
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_req_type   <= REQ_INSERT;
        i_item_value <= '0;
        i_position   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list cases
        send_request(REQ_SEARCH,  32'sd5, 6'd0);
        send_request(REQ_REMOVE,  32'sd5, 6'd0);
        send_request(REQ_REPLACE, 32'sd5, 6'd0);
        // extremes and duplicates
        send_request(REQ_INSERT,  32'sh7fff_ffff, 6'd0);
        send_request(REQ_INSERT,  32'sh8000_0000, 6'd0);
        send_request(REQ_INSERT,  32'sd0, 6'd0);
        send_request(REQ_INSERT,  -32'sd1, 6'd0);
        send_request(REQ_INSERT,  32'sd0, 6'd0);
        send_request(REQ_INSERT,  32'sd0, 6'd0);
        send_request(REQ_SEARCH,  32'sd0, 6'd0);
        send_request(REQ_SEARCH,  32'sh8000_0000, 6'd0);
        send_request(REQ_SEARCH,  32'sh7fff_ffff, 6'd0);
        // early stop once the scan passes the value; then removes and replaces
        send_request(REQ_SEARCH,  32'sd5, 6'd0);
        send_request(REQ_SEARCH,  32'sh7fff_fffe, 6'd0);
        send_request(REQ_REMOVE,  32'sd3, 6'd0);
        send_request(REQ_REMOVE,  32'sd0, 6'd0);
        send_request(REQ_REPLACE, 32'sd100, 6'd0);
        send_request(REQ_REPLACE, 32'sd7, 6'd63);
        send_request(REQ_REPLACE, 32'sd7, 6'd3);
        send_request(REQ_REPLACE, 32'sh8000_0000, 6'd2);
        send_request(REQ_REMOVE,  32'sh7fff_ffff, 6'd0);
        send_request(REQ_INSERT,  32'shaaaa_aaaa, 6'd0);
        send_request(REQ_INSERT,  32'sh5555_5555, 6'd0);
        send_request(REQ_REPLACE, 32'sh5555_5555, 6'd0);
        wait_for_results();

        // phases alternate between insert-heavy filling and a draining or uniform mix
        sent = 0;
        mode = 0;
        while (sent < NUM_RANDOM) begin
            len = $urandom_range(40, 120);
            for (int n = 0; n < len && sent < NUM_RANDOM; n++) begin
                if (sent >= NUM_RANDOM - CALM_TAIL) idle_on = 1'b0;
                send_request(pick_request(mode), pick_value(), pick_position());
                sent++;
            end
            if (idle_on && $urandom_range(0, 2) == 0) wait_for_results();
            mode = (mode == 0) ? $urandom_range(1, 2) : 0;
        end

        wait_for_results();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("sorted_list_engine: match");
        end else begin
            $display("sorted_list_engine: mismatch");
        end
        $finish;
    end
endmodule

/* sorted_list_engine.f */
rtl/core/sle_pkg.sv
rtl/core/sle_ram.sv
rtl/core/sle_seq.sv
rtl/core/sorted_list_engine.sv
rtl/core/sle_checker.sv
test/sorted_list_engine_tb.sv
